FILE: sv/ant_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ant_pkg;
  localparam int unsigned TableDepthDef = 16;
  localparam int unsigned IdBytesDef = 8;
  localparam logic [31:0] TimeoutReset = 32'd60000;
  localparam logic [15:0] AckMax = 16'hFFFF;
  localparam logic [9:0] Permille = 10'd1000;
  localparam logic signed [8:0] AvgNone = -9'sd90;
  localparam logic signed [8:0] RssiAbsent = -9'sd128;

  typedef enum logic [2:0] {
    OP_HELLO = 3'd0,
    OP_SET_RSSI = 3'd1,
    OP_SET_BATT = 3'd2,
    OP_ACK_SENT = 3'd3,
    OP_ACK_RECV = 3'd4,
    OP_LOOKUP = 3'd5,
    OP_READ_SLOT = 3'd6,
    OP_STATS = 3'd7
  } op_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_APPLY = 6'b000100,
    ST_DIV = 6'b001000,
    ST_AVG = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;
endpackage
`default_nettype wire

FILE: sv/aging_neighbor_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Neighbor table with aging. A request is taken when start is high and busy is low;
// its single result is marked by out_valid, which is high for exactly one cycle,
// and cannot be held off. Every request scans the table one entry per cycle,
// then applies its update in ST_APPLY. A lookup with a nonzero sent counter
// then runs the bit-serial permille divider (ST_DIV), and statistics with at
// least one live entry of nonzero RSSI run the bit-serial average divider
// (ST_AVG) before the result. The timeout register may be written through cfg_
// whenever the block is idle and start is low.
module aging_neighbor_table #(
  parameter int unsigned TABLE_DEPTH = ant_pkg::TableDepthDef,
  parameter int unsigned ID_BYTES = ant_pkg::IdBytesDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_op,
  input  wire logic [63:0] in_node_id,
  input  wire logic signed [8:0] in_rssi_in,
  input  wire logic [15:0] in_battery_in,
  input  wire logic [7:0]  in_slot,
  input  wire logic [31:0] in_now_ms,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_timeout_ms,
  output logic             out_valid,
  output logic             out_ok,
  output logic [63:0]      out_node_id_out,
  output logic signed [8:0] out_rssi_out,
  output logic             out_online,
  output logic [31:0]      out_freshness_ms,
  output logic [15:0]      out_battery_out,
  output logic signed [10:0] out_ack_permille,
  output logic [4:0]       out_live_count,
  output logic signed [8:0] out_min_rssi,
  output logic signed [8:0] out_avg_rssi
);
  import ant_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IDW = 8 * ID_BYTES;
  localparam int SW = 9 + CW;
  // The remainder must hold any value below a 16-bit ack divisor.
  localparam int RW = (SW > 16) ? SW : 16;

  logic [IDW-1:0] ent_id [TABLE_DEPTH];
  logic signed [8:0] ent_rssi [TABLE_DEPTH];
  logic [31:0] ent_seen [TABLE_DEPTH];
  logic [15:0] ent_batt [TABLE_DEPTH];
  logic [15:0] ent_sent [TABLE_DEPTH];
  logic [15:0] ent_recv [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_r;

  logic [31:0] timeout_r;
  state_t state_r;
  op_t op_r;
  logic [IDW-1:0] id_r;
  logic signed [8:0] rssi_r;
  logic [15:0] batt_r;
  logic [7:0] slot_r;
  logic [31:0] now_r;
  logic [IW-1:0] idx_r;
  logic found_r, free_r;
  logic [IW-1:0] match_r, free_idx_r;
  logic [CW-1:0] cnt_r, n_r;
  logic signed [SW-1:0] sum_r;
  logic signed [8:0] min_r;
  logic any_r;
  // Shared restoring divider.
  logic [SW-1:0] quo_r, den_r;
  logic [RW-1:0] rem_r;
  logic [4:0] step_r;

  logic ok_r, online_r;
  logic [63:0] nid_r;
  logic signed [8:0] rout_r, avg_r;
  logic [31:0] fresh_r;
  logic [15:0] bout_r;
  logic signed [10:0] ack_r;
  logic sign_r;

  logic [31:0] age;
  logic live, match, claim;
  logic [RW:0] rem_shift;

  assign age = now_r - ent_seen[idx_r];
  assign live = valid_r[idx_r] && (age < timeout_r);
  assign match = valid_r[idx_r] && (ent_id[idx_r] == id_r);
  assign claim = !valid_r[idx_r] || (age > timeout_r);
  assign rem_shift = {rem_r, quo_r[SW-1]};

  assign busy = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE) && !start;

  always_ff @(posedge clk) begin
    out_valid <= 1'b0;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      timeout_r <= TimeoutReset;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        ent_id[i] <= '0; ent_rssi[i] <= '0; ent_seen[i] <= '0;
        ent_batt[i] <= '0; ent_sent[i] <= '0; ent_recv[i] <= '0;
      end
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cfg_valid && cfg_ready) timeout_r <= cfg_timeout_ms;
          if (start) begin
            op_r <= op_t'(in_op);
            id_r <= in_node_id[IDW-1:0];
            rssi_r <= in_rssi_in;
            batt_r <= in_battery_in;
            slot_r <= in_slot;
            now_r <= in_now_ms;
            idx_r <= '0;
            found_r <= 1'b0; free_r <= 1'b0;
            cnt_r <= '0; n_r <= '0; sum_r <= '0; min_r <= '0; any_r <= 1'b0;
            ok_r <= 1'b0; online_r <= 1'b0; nid_r <= '0; rout_r <= '0;
            fresh_r <= '0; bout_r <= '0; ack_r <= '0; avg_r <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (match && !found_r) begin
            found_r <= 1'b1; match_r <= idx_r;
          end
          if (claim && !free_r) begin
            free_r <= 1'b1; free_idx_r <= idx_r;
          end
          if (live) begin
            cnt_r <= cnt_r + 1'b1;
            if (ent_rssi[idx_r] != 0) begin
              if (!any_r || ent_rssi[idx_r] < min_r) min_r <= ent_rssi[idx_r];
              any_r <= 1'b1;
              sum_r <= sum_r + SW'(ent_rssi[idx_r]);
              n_r <= n_r + 1'b1;
            end
          end
          if (slot_r[IW-1:0] == idx_r && ((TABLE_DEPTH >= 256) ||
              (slot_r < 8'(TABLE_DEPTH))) && live) begin
            ok_r <= (op_r == OP_READ_SLOT);
            if (op_r == OP_READ_SLOT) begin
              nid_r <= 64'(ent_id[idx_r]);
              rout_r <= ent_rssi[idx_r];
            end
          end
          if (32'(idx_r) == TABLE_DEPTH - 1) state_r <= ST_APPLY;
          else idx_r <= idx_r + 1'b1;
        end
        ST_APPLY: begin
          idx_r <= match_r;
          state_r <= ST_DONE;
          case (op_r)
            OP_HELLO: begin
              if (found_r) begin
                ent_rssi[match_r] <= rssi_r; ent_seen[match_r] <= now_r;
              end else if (free_r) begin
                ent_id[free_idx_r] <= id_r; ent_rssi[free_idx_r] <= rssi_r;
                ent_seen[free_idx_r] <= now_r; valid_r[free_idx_r] <= 1'b1;
                ok_r <= 1'b1;
              end
            end
            OP_SET_RSSI: if (found_r) begin
              ent_rssi[match_r] <= rssi_r; ok_r <= 1'b1;
            end
            OP_SET_BATT: if (found_r) begin
              ok_r <= 1'b1;
              if (batt_r != 0) begin
                ent_batt[match_r] <= batt_r; ent_seen[match_r] <= now_r;
              end
            end
            OP_ACK_SENT: if (found_r) begin
              ok_r <= 1'b1;
              if (ent_sent[match_r] != AckMax) ent_sent[match_r] <= ent_sent[match_r] + 1'b1;
            end
            OP_ACK_RECV: if (found_r) begin
              ok_r <= 1'b1;
              if (ent_recv[match_r] != AckMax) ent_recv[match_r] <= ent_recv[match_r] + 1'b1;
            end
            OP_LOOKUP: begin
              rout_r <= RssiAbsent; fresh_r <= '1; ack_r <= -11'sd1;
              if (found_r) begin
                ok_r <= 1'b1;
                bout_r <= ent_batt[match_r];
                if (valid_r[match_r] &&
                    (now_r - ent_seen[match_r]) < timeout_r) begin
                  rout_r <= ent_rssi[match_r]; online_r <= 1'b1;
                  fresh_r <= now_r - ent_seen[match_r];
                end
                if (ent_sent[match_r] == 0 && ent_recv[match_r] != 0) ack_r <= 11'sd1000;
                else if (ent_sent[match_r] != 0) begin
                  // Clamped received count times 1000 divided by sent, one bit a cycle.
                  quo_r <= '0; rem_r <= '0; step_r <= '0; state_r <= ST_DIV;
                end
              end
            end
            OP_STATS: begin
              if (n_r == 0) avg_r <= AvgNone;
              else begin
                sign_r <= sum_r[SW-1];
                quo_r <= sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
                den_r <= SW'(n_r);
                rem_r <= '0; step_r <= '0; state_r <= ST_AVG;
              end
            end
            default: ;
          endcase
        end
        ST_DIV: begin
          // 26-bit dividend: min(recv,sent)*1000 fits below 2^26.
          begin : divblk
            logic [15:0] rc;
            logic [25:0] dvd;
            logic [16:0] rs;
            rc = (ent_recv[idx_r] > ent_sent[idx_r]) ? ent_sent[idx_r] : ent_recv[idx_r];
            dvd = {10'd0, rc} * {16'd0, Permille};
            rs = {rem_r[15:0], dvd[5'd25 - step_r]};
            if (rs >= {1'b0, ent_sent[idx_r]}) begin
              rem_r <= RW'(rs - {1'b0, ent_sent[idx_r]});
              quo_r <= {quo_r[SW-2:0], 1'b1};
            end else begin
              rem_r <= RW'(rs);
              quo_r <= {quo_r[SW-2:0], 1'b0};
            end
            if (step_r == 5'd25) begin
              state_r <= ST_DONE;
              ack_r <= (rs >= {1'b0, ent_sent[idx_r]}) ?
                  11'({quo_r[9:0], 1'b1}) : 11'({quo_r[9:0], 1'b0});
            end
            step_r <= step_r + 1'b1;
          end
        end
        ST_AVG: begin
          if (rem_shift >= (RW + 1)'(den_r)) begin
            rem_r <= RW'(rem_shift - (RW + 1)'(den_r));
            quo_r <= {quo_r[SW-2:0], 1'b1};
          end else begin
            rem_r <= RW'(rem_shift);
            quo_r <= {quo_r[SW-2:0], 1'b0};
          end
          step_r <= step_r + 1'b1;
          if (step_r == 5'(SW - 1)) state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (op_r == OP_STATS && n_r != 0)
            avg_r <= sign_r ? -9'(quo_r) : 9'(quo_r);
          out_valid <= 1'b1;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ok = ok_r;
  assign out_node_id_out = nid_r;
  assign out_rssi_out = rout_r;
  assign out_online = online_r;
  assign out_freshness_ms = fresh_r;
  assign out_battery_out = bout_r;
  assign out_ack_permille = ack_r;
  assign out_live_count = (op_r == OP_STATS) ? 5'(cnt_r) : 5'd0;
  assign out_min_rssi = (op_r == OP_STATS) ? min_r : 9'sd0;
  assign out_avg_rssi = avg_r;
endmodule
`default_nettype wire
